>>> hw/rtl/pma_pkg.sv
// Package for the priority mode arbiter: mode lifecycle and opcode codes,
// reset priorities and the winner-selection function.
// No dependencies.
package pma_pkg;

    localparam int NumModes = 4;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_SAFETY = 2'd3;
    localparam logic [2:0] NO_WINNER   = 3'd4;

    typedef enum logic [1:0] {
        LC_INACTIVE    = 2'd0,
        LC_ACTIVE      = 2'd1,
        LC_INTERRUPTED = 2'd2
    } lc_t;

    typedef enum logic [2:0] {
        OP_ACTIVATE   = 3'd0,
        OP_INTERRUPT  = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_RESET_IDLE = 3'd3,
        OP_UPDATE     = 3'd4,
        OP_QUERY      = 3'd5,
        OP_MOTION     = 3'd6
    } op_t;

    typedef lc_t [NumModes-1:0] lc_arr_t;
    typedef logic [NumModes-1:0][7:0] prio_arr_t;

    localparam prio_arr_t PRIO_RESET = {8'd255, 8'd60, 8'd40, 8'd1};

    // Highest-priority active mode; equal priorities go to the higher index.
    function automatic logic [2:0] winner(input lc_arr_t lc, input prio_arr_t prio);
        logic [2:0] w;
        logic [7:0] wp;
        w  = NO_WINNER;
        wp = 8'd0;
        for (int i = 0; i < NumModes; i++) begin
            if (lc[i] == LC_ACTIVE && (w == NO_WINNER || prio[i] >= wp)) begin
                w  = 3'(i);
                wp = prio[i];
            end
        end
        return w;
    endfunction

endpackage

>>> hw/rtl/priority_mode_arbiter.sv
// Top level of the priority mode arbiter: input register, one-pass
// lifecycle update and arbitration, result register, config registers.
// Depends on pma_pkg.
//
// Usage:
//  - Command channel: an item (opcode, task_id, now_ms, command_present) is
//    taken at a rising edge with start high and busy low. busy stays low, so
//    an item may be issued on every cycle.
//  - Result channel: done is high for exactly one cycle with accepted,
//    winner_task, winner_priority, task_state and task_since_ms. The
//    receiver cannot stall; results are never held back.
//  - Timing: an item passes the input register, then the result register,
//    which drives the ports. Throughput is one item per cycle, set by the
//    single registered pass: the state written with one item's result is
//    what the next item, arbitrated in the following cycle, sees.
//  - Config: cfg_valid/cfg_ready write priority register cfg_index with cfg_data;
//    cfg_ready is always high. The user must write only while idle; the block does not enforce it.
//  - Reset (rst_n low, async): priorities 1/40/60/255, idle active, other
//    modes inactive, all timestamps zero, no result pending.
module priority_mode_arbiter (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [1:0]  task_id,
    input  logic [31:0] now_ms,
    input  logic        command_present,
    // result channel
    output logic        done,
    output logic        accepted,
    output logic [2:0]  winner_task,
    output logic [7:0]  winner_priority,
    output logic [1:0]  task_state,
    output logic [31:0] task_since_ms,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // input register
    logic              in_valid_reg;
    pma_pkg::op_t      op_reg;
    logic [1:0]        tid_reg;
    logic [31:0]       now_reg;
    logic              cmd_reg;

    // architectural state
    pma_pkg::prio_arr_t prio_reg;
    pma_pkg::lc_arr_t   lc_reg, lc_next;
    logic [pma_pkg::NumModes-1:0][31:0] tm_reg, tm_next;

    // result register
    logic        done_reg;
    logic        ok_reg, ok_next;
    logic [2:0]  win_reg, win_next;
    logic [7:0]  wprio_reg, wprio_next;
    logic [1:0]  tstate_reg, tstate_next;
    logic [31:0] tsince_reg, tsince_next;

    logic [2:0]  win_before;
    logic        act_ok;
    logic        do_act;
    logic        do_fall;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg  <= pma_pkg::op_t'(opcode);
            tid_reg <= task_id;
            now_reg <= now_ms;
            cmd_reg <= command_present;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg <= pma_pkg::PRIO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            prio_reg[cfg_index] <= cfg_data;
        end
    end

    // Winner before the step and the activate refusal test.
    assign win_before = pma_pkg::winner(lc_reg, prio_reg);
    assign act_ok = !(win_before != pma_pkg::NO_WINNER && win_before[1:0] != tid_reg
                      && prio_reg[tid_reg] < prio_reg[win_before[1:0]]);

    always_comb
    begin
        lc_next = lc_reg;
        tm_next = tm_reg;
        ok_next = 1'b1;
        do_act  = 1'b0;
        do_fall = 1'b0;

        case (op_reg)
            pma_pkg::OP_ACTIVATE:
            begin
                do_act = 1'b1;
            end
            pma_pkg::OP_INTERRUPT:
            begin
                if (lc_reg[tid_reg] != pma_pkg::LC_ACTIVE)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    lc_next[tid_reg] = pma_pkg::LC_INTERRUPTED;
                    do_fall = (pma_pkg::winner(lc_next, prio_reg) == pma_pkg::NO_WINNER);
                end
            end
            pma_pkg::OP_CLEAR:
            begin
                lc_next[tid_reg] = pma_pkg::LC_INACTIVE;
                tm_next[tid_reg] = now_reg;
                do_fall = (tid_reg != pma_pkg::MODE_IDLE)
                          && (pma_pkg::winner(lc_next, prio_reg) == pma_pkg::NO_WINNER);
            end
            pma_pkg::OP_RESET_IDLE:
            begin
                do_fall = 1'b1;
            end
            pma_pkg::OP_UPDATE:
            begin
                // safety hold winning parks idle
                if (win_before == {1'b0, pma_pkg::MODE_SAFETY})
                begin
                    lc_next[pma_pkg::MODE_IDLE] = pma_pkg::LC_INTERRUPTED;
                end
            end
            pma_pkg::OP_QUERY:
            begin
                ok_next = 1'b1;
            end
            pma_pkg::OP_MOTION:
            begin
                if (!cmd_reg || tid_reg == pma_pkg::MODE_IDLE
                    || tid_reg == pma_pkg::MODE_SAFETY)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    do_act = 1'b1;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase

        if (do_act)
        begin
            if (!act_ok)
            begin
                ok_next = 1'b0;
            end
            else
            begin
                if (win_before != pma_pkg::NO_WINNER && win_before[1:0] != tid_reg)
                begin
                    lc_next[win_before[1:0]] = pma_pkg::LC_INTERRUPTED;
                end
                lc_next[tid_reg] = pma_pkg::LC_ACTIVE;
                tm_next[tid_reg] = now_reg;
            end
        end

        // fall back to idle
        if (do_fall)
        begin
            for (int i = 1; i < pma_pkg::NumModes; i++)
            begin
                if (lc_next[i] == pma_pkg::LC_ACTIVE)
                begin
                    lc_next[i] = pma_pkg::LC_INTERRUPTED;
                end
            end
            lc_next[pma_pkg::MODE_IDLE] = pma_pkg::LC_ACTIVE;
            tm_next[pma_pkg::MODE_IDLE] = now_reg;
        end

        win_next    = pma_pkg::winner(lc_next, prio_reg);
        wprio_next  = (win_next == pma_pkg::NO_WINNER) ? 8'd0 : prio_reg[win_next[1:0]];
        tstate_next = lc_next[tid_reg];
        tsince_next = tm_next[tid_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            for (int i = 0; i < pma_pkg::NumModes; i++)
            begin
                lc_reg[i] <= (i == 0) ? pma_pkg::LC_ACTIVE : pma_pkg::LC_INACTIVE;
                tm_reg[i] <= 32'd0;
            end
        end
        else
        begin
            done_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                lc_reg <= lc_next;
                tm_reg <= tm_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            ok_reg     <= ok_next;
            win_reg    <= win_next;
            wprio_reg  <= wprio_next;
            tstate_reg <= tstate_next;
            tsince_reg <= tsince_next;
        end
    end

    assign done            = done_reg;
    assign accepted        = ok_reg;
    assign winner_task     = win_reg;
    assign winner_priority = wprio_reg;
    assign task_state      = tstate_reg;
    assign task_since_ms   = tsince_reg;

`ifndef SYNTH
    // every item taken yields a result once it has passed the input and result registers
    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("item without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid_reg))
        else $error("result without item");

    a_none_prio: assert property (@(posedge clk) disable iff (!rst_n)
        (done && winner_task == pma_pkg::NO_WINNER) |-> winner_priority == 8'd0)
        else $error("priority reported with no winner");

    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && op_reg == pma_pkg::OP_RESET_IDLE)
            |=> lc_reg[pma_pkg::MODE_IDLE] == pma_pkg::LC_ACTIVE && winner_task != pma_pkg::NO_WINNER)
        else $error("fall back to idle left no winner");
`endif

endmodule
